@@ hw/rtl/rrts_pkg.sv @@
package rrts_pkg;

   localparam int STACK_W    = 64;
   localparam int TASK_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int OP_W       = 2;
   localparam int RSP_PAD_W  = 4;
   localparam int RSP_DATA_W = STACK_W + TASK_W + RSP_PAD_W;

   // initial frame: 20 words of 8 bytes
   localparam logic [STACK_W-1:0] FRAME_BYTES = 64'd160;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_HALTED = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE   = 2'd0,
      OP_SCHEDULE = 2'd1,
      OP_EXIT     = 2'd2,
      OP_NONE     = 2'd3
   } task_op_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic do_create;
      logic do_full;
      logic do_halted;
      logic do_other;
      logic do_save;
      logic do_retire;
      logic scan_next;
      logic take_found;
      logic none_sched;
      logic none_exit;
      logic take_rdata;
      logic emit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      task_op_type op;
      logic        halted;
      logic        full;
      logic        hit;
      logic        scan_last;
      logic        out_free;
   } dp_status_type;

endpackage

@@ hw/rtl/rrts_ram.sv @@
module rrts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/rrts_dpath.sv @@
module rrts_dpath #(
   parameter int MAX_TASKS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rrts_pkg::dp_cmd_type            cmd,
   output rrts_pkg::dp_status_type         status,
   input  logic [rrts_pkg::STACK_W-1:0]    req_tdata,
   input  logic [rrts_pkg::OP_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [rrts_pkg::STATUS_W-1:0]   rsp_tuser
);
   import rrts_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   // control state
   logic [MAX_TASKS-1:0] active_ff, active_in;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 halted_ff, halted_in;
   logic                 out_valid_ff, out_valid_in;

   // payload
   task_op_type          op_ff, op_in;
   logic [STACK_W-1:0]   sv_ff, sv_in;
   logic [IDX_W-1:0]     cand_ff, cand_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [STACK_W-1:0]   res_stack_ff, res_stack_in;
   logic [TASK_W-1:0]    res_task_ff, res_task_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [STACK_W-1:0]   out_stack_ff, out_stack_in;
   logic [TASK_W-1:0]    out_task_ff, out_task_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;

   logic [STACK_W-1:0]   frame;
   logic [IDX_W-1:0]     new_idx;
   logic [CNT_W-1:0]     cur_plus;
   logic [CNT_W-1:0]     cand_plus;
   logic [IDX_W-1:0]     first_cand;
   logic [IDX_W-1:0]     next_cand;
   logic                 out_free;

   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [STACK_W-1:0]   ram_wr_data;
   logic [STACK_W-1:0]   ram_rd_data;

   always_comb begin
      frame      = sv_ff - FRAME_BYTES;
      new_idx    = total_ff[IDX_W-1:0];
      cur_plus   = CNT_W'(cur_ff) + CNT_W'(1);
      cand_plus  = CNT_W'(cand_ff) + CNT_W'(1);
      // wrap at the task count, not at the table size
      first_cand = (cur_plus == total_ff) ? '0 : cur_plus[IDX_W-1:0];
      next_cand  = (cand_plus == total_ff) ? '0 : cand_plus[IDX_W-1:0];
      out_free   = !out_valid_ff || rsp_tready;

      ram_wr_en   = cmd.do_create || cmd.do_save;
      ram_wr_addr = cmd.do_create ? new_idx : cur_ff;
      ram_wr_data = cmd.do_create ? frame : sv_ff;
   end

   always_comb begin
      active_in     = active_ff;
      total_in      = total_ff;
      cur_in        = cur_ff;
      halted_in     = halted_ff;
      out_valid_in  = out_valid_ff;
      op_in         = op_ff;
      sv_in         = sv_ff;
      cand_in       = cand_ff;
      step_in       = step_ff;
      res_stack_in  = res_stack_ff;
      res_task_in   = res_task_ff;
      res_status_in = res_status_ff;
      out_stack_in  = out_stack_ff;
      out_task_in   = out_task_ff;
      out_status_in = out_status_ff;

      if (cmd.capture) begin
         op_in = task_op_type'(req_tuser);
         sv_in = req_tdata;
      end

      if (cmd.do_create) begin
         active_in[new_idx] = 1'b1;
         total_in           = total_ff + CNT_W'(1);
         res_stack_in       = frame;
         res_task_in        = TASK_W'(new_idx);
         res_status_in      = ST_OK;
      end

      if (cmd.do_full) begin
         res_stack_in  = '0;
         res_task_in   = '0;
         res_status_in = ST_FULL;
      end

      if (cmd.do_halted || cmd.none_exit) begin
         res_stack_in  = '0;
         res_task_in   = TASK_W'(cur_ff);
         res_status_in = ST_HALTED;
      end

      if (cmd.none_exit) begin
         halted_in = 1'b1;
      end

      if (cmd.do_other) begin
         res_stack_in  = '0;
         res_task_in   = TASK_W'(cur_ff);
         res_status_in = ST_OK;
      end

      if (cmd.do_retire) begin
         active_in[cur_ff] = 1'b0;
      end

      if (cmd.do_save || cmd.do_retire) begin
         cand_in = first_cand;
         step_in = '0;
      end

      if (cmd.scan_next) begin
         cand_in = next_cand;
         step_in = step_ff + CNT_W'(1);
      end

      if (cmd.take_found) begin
         cur_in = cand_ff;
      end

      if (cmd.none_sched) begin
         res_stack_in  = sv_ff;
         res_task_in   = TASK_W'(cur_ff);
         res_status_in = ST_OK;
      end

      if (cmd.take_rdata) begin
         res_stack_in  = ram_rd_data;
         res_task_in   = TASK_W'(cur_ff);
         res_status_in = ST_OK;
      end

      if (cmd.emit) begin
         out_stack_in  = res_stack_ff;
         out_task_in   = res_task_ff;
         out_status_in = res_status_ff;
         out_valid_in  = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= MAX_TASKS'(1);
         total_ff     <= CNT_W'(1);
         cur_ff       <= '0;
         halted_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         total_ff     <= total_in;
         cur_ff       <= cur_in;
         halted_ff    <= halted_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sv_ff         <= sv_in;
      cand_ff       <= cand_in;
      step_ff       <= step_in;
      res_stack_ff  <= res_stack_in;
      res_task_ff   <= res_task_in;
      res_status_ff <= res_status_in;
      out_stack_ff  <= out_stack_in;
      out_task_ff   <= out_task_in;
      out_status_ff <= out_status_in;
   end

   rrts_ram #(
      .WIDTH (STACK_W),
      .DEPTH (MAX_TASKS)
   ) u_saved_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.take_found),
      .rd_addr (cand_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      status.op        = op_ff;
      status.halted    = halted_ff;
      status.full      = (total_ff == CNT_W'(MAX_TASKS));
      status.hit       = active_ff[cand_ff];
      status.scan_last = (CNT_W'(step_ff + CNT_W'(1)) == total_ff);
      status.out_free  = out_free;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), out_task_ff, out_stack_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

@@ hw/rtl/rrts_ctrl.sv @@
module rrts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rrts_pkg::dp_status_type status,
   output rrts_pkg::dp_cmd_type    cmd
);
   import rrts_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FETCH,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = (state_ff == S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_EMIT;
            if (status.halted) begin
               cmd.do_halted = 1'b1;
            end else begin
               case (status.op)
                  OP_CREATE: begin
                     if (status.full) begin
                        cmd.do_full = 1'b1;
                     end else begin
                        cmd.do_create = 1'b1;
                     end
                  end
                  OP_SCHEDULE: begin
                     cmd.do_save = 1'b1;
                     state_in    = S_SCAN;
                  end
                  OP_EXIT: begin
                     cmd.do_retire = 1'b1;
                     state_in      = S_SCAN;
                  end
                  default: begin
                     cmd.do_other = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (status.hit) begin
               cmd.take_found = 1'b1;
               state_in       = S_FETCH;
            end else if (status.scan_last) begin
               if (status.op == OP_SCHEDULE) begin
                  cmd.none_sched = 1'b1;
               end else begin
                  cmd.none_exit = 1'b1;
               end
               state_in = S_EMIT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         S_FETCH: begin
            cmd.take_rdata = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/round_robin_task_switcher.sv @@
// Channel   Ports                        Contents
// --------  ---------------------------  ------------------------------------------
// request   req_tvalid/tready/tdata/tuser tuser: command; tdata: stack_value
// response  rsp_tvalid/tready/tdata/tuser tdata: result_stack, result_task; tuser: status
//
// One request at a time: accept, decode, a round-robin scan of one task
// per cycle, a saved-pointer read, then the result. Create, halted and
// unknown requests skip the scan and the read; schedule and exit requests
// scan the active flags of up to task_total tasks.
// Reset leaves one task, task 0, active and current.
// A stalled response is held in the output register while the next request is taken.
module round_robin_task_switcher #(
   parameter int MAX_TASKS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rrts_pkg::STACK_W-1:0]    req_tdata,  // [63:0] stack_value
   input  logic [rrts_pkg::OP_W-1:0]       req_tuser,  // [1:0] command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [63:0] result_stack, [67:64] result_task
   output logic [rrts_pkg::STATUS_W-1:0]   rsp_tuser   // [1:0] status
);
   import rrts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrts_dpath #(
      .MAX_TASKS (MAX_TASKS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ hw/rtl/rrts_checker.sv @@
module rrts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [rrts_pkg::STATUS_W-1:0]   rsp_tuser
);
   import rrts_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_FULL |-> rsp_tdata[STACK_W+TASK_W-1:0] == '0)
      else $error("table-full response carries data");

   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_HALTED |-> rsp_tdata[STACK_W-1:0] == '0)
      else $error("halted response carries a stack pointer");

endmodule

bind round_robin_task_switcher rrts_checker u_checker (.*);

@@ bench/tb_round_robin_task_switcher.sv @@
module tb_round_robin_task_switcher;
   timeunit 1ns;
   timeprecision 1ps;

   import rrts_pkg::*;

   localparam int TASK_SLOTS   = 16;
   localparam int RANDOM_ITEMS = 1720;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 400;

   typedef struct {
      logic [STACK_W-1:0]  stack;
      logic [TASK_W-1:0]   task_id;
      logic [STATUS_W-1:0] status;
   } answer_type;

   // Shadow copy of the task table; predicts one answer per accepted request.
   class task_table_tracker;
      logic [STACK_W-1:0] saved_ptr [TASK_SLOTS];
      bit                 active [TASK_SLOTS];
      int                 task_total;
      int                 current_id;
      bit                 halted;
      answer_type         answers [$];
      int                 failures;
      int                 checked;
      int                 full_seen;

      function new();
         foreach (saved_ptr[i]) begin
            saved_ptr[i] = '0;
            active[i]    = 1'b0;
         end
         active[0]  = 1'b1;
         task_total = 1;
         current_id = 0;
         halted     = 1'b0;
         failures   = 0;
         checked    = 0;
         full_seen  = 0;
      endfunction

      // round-robin search after the current task; current task comes last
      function int next_active();
         int cand;
         for (int i = 0; i < task_total; i++) begin
            cand = (current_id + 1 + i) % task_total;
            if (active[cand]) return cand;
         end
         return -1;
      endfunction

      function int live_tasks();
         int n;
         n = 0;
         foreach (active[i]) n += active[i];
         return n;
      endfunction

      function int pending();
         return answers.size();
      endfunction

      function void note_request(task_op_type op, logic [STACK_W-1:0] value);
         answer_type a;
         int         nxt;
         a.stack   = '0;
         a.task_id = current_id[TASK_W-1:0];
         a.status  = ST_OK;
         if (halted) begin
            a.status = ST_HALTED;
         end else begin
            case (op)
               OP_CREATE: begin
                  if (task_total >= TASK_SLOTS) begin
                     a.task_id = '0;
                     a.status  = ST_FULL;
                     full_seen++;
                  end else begin
                     saved_ptr[task_total] = value - FRAME_BYTES;
                     active[task_total]    = 1'b1;
                     a.stack   = saved_ptr[task_total];
                     a.task_id = task_total[TASK_W-1:0];
                     task_total++;
                  end
               end
               OP_SCHEDULE: begin
                  saved_ptr[current_id] = value;
                  nxt = next_active();
                  if (nxt >= 0) begin
                     current_id = nxt;
                     a.stack    = saved_ptr[nxt];
                     a.task_id  = nxt[TASK_W-1:0];
                  end else begin
                     a.stack = value;
                  end
               end
               OP_EXIT: begin
                  active[current_id] = 1'b0;
                  nxt = next_active();
                  if (nxt >= 0) begin
                     current_id = nxt;
                     a.stack    = saved_ptr[nxt];
                     a.task_id  = nxt[TASK_W-1:0];
                  end else begin
                     halted   = 1'b1;
                     a.status = ST_HALTED;
                  end
               end
               default: ;
            endcase
         end
         answers.push_back(a);
      endfunction

      function void check_answer(logic [STACK_W-1:0] stack, logic [TASK_W-1:0] task_id,
                                 logic [STATUS_W-1:0] status);
         answer_type a;
         checked++;
         if (answers.size() == 0) begin
            $error("response with no request outstanding: stack %h task %0d status %0d",
                   stack, task_id, status);
            failures++;
            return;
         end
         a = answers.pop_front();
         if (stack !== a.stack) begin
            $error("result_stack: expected %h, actual %h", a.stack, stack);
            failures++;
         end
         if (task_id !== a.task_id) begin
            $error("result_task: expected %0d, actual %0d", a.task_id, task_id);
            failures++;
         end
         if (status !== a.status) begin
            $error("status: expected %0d, actual %0d", a.status, status);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [STACK_W-1:0]    req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;

   task_table_tracker tracker = new();
   int          send_idle_pct = 20;
   int          recv_idle_pct = 61;
   bit          long_hold_request = 1'b0;
   int unsigned cycle_count = 0;

   round_robin_task_switcher #(.MAX_TASKS(TASK_SLOTS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [STACK_W-1:0] random_pointer();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return STACK_W'($urandom_range(319));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one request after random idle cycles; return once it is taken.
   task automatic send_request(task_op_type op, logic [STACK_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {$urandom, $urandom};
         req_tuser  <= OP_W'($urandom_range(3));
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, value);
   endtask

   // Hold the request side until every answer is back.
   task automatic drain_answers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   // receiver: check responses, stall at random or for one long stretch
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            tracker.check_answer(rsp_tdata[STACK_W-1:0], rsp_tdata[STACK_W +: TASK_W],
                                 rsp_tuser);
         if (hold_left == 0 && long_hold_request) begin
            hold_left = LONG_HOLD;
            long_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      task_op_type op;
      int          pick;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_CREATE;
      rsp_tready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // only task 0 exists: schedule keeps it, unknown op answers zero
      send_request(OP_SCHEDULE, '0);
      send_request(OP_SCHEDULE, '1);
      send_request(OP_NONE, '1);
      // creates, including stack tops that wrap below the frame size
      send_request(OP_CREATE, '0);
      send_request(OP_CREATE, 64'd159);
      send_request(OP_CREATE, 64'd160);
      send_request(OP_CREATE, '1);
      send_request(OP_SCHEDULE, 64'h5555_5555_5555_5555);
      send_request(OP_EXIT, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(OP_SCHEDULE, 64'h0123_4567_89ab_cdef);
      send_request(OP_SCHEDULE, 64'hfedc_ba98_7654_3210);
      // back to task 0, wrapping past the last task
      send_request(OP_SCHEDULE, 64'h8000_0000_0000_0001);
      send_request(OP_NONE, '0);
      send_request(OP_EXIT, '1);
      send_request(OP_SCHEDULE, 64'h7fff_ffff_ffff_fffe);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            drain_answers();
            send_idle_pct = 61;
            recv_idle_pct = 20;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            drain_answers();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == 5 * RANDOM_ITEMS / 6)
            long_hold_request = 1'b1;
         pick = $urandom_range(99);
         if (pick < 12)
            op = OP_CREATE;
         else if (pick < 17)
            op = OP_NONE;
         else if (pick < 18 && tracker.live_tasks() > 2)
            op = OP_EXIT;
         else
            op = OP_SCHEDULE;
         send_request(op, random_pointer());
      end

      // retire every remaining task, then poke the halted block with each op
      while (tracker.live_tasks() > 0)
         send_request(OP_EXIT, random_pointer());
      for (int k = 0; k < 4; k++)
         send_request(task_op_type'(k), random_pointer());
      req_tvalid <= 1'b0;

      do @(posedge clock); while (tracker.pending() != 0);
      repeat (40) @(posedge clock);

      $display("checked %0d responses over create, schedule, exit and unknown requests",
               tracker.checked);
      $display("table grew to %0d tasks, %0d full answers, halted state %0s",
               tracker.task_total, tracker.full_seen, tracker.halted ? "reached" : "missed");
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
